### hw/rtl/pnoq_pkg.sv
// shared types and constants of the pending note-off queue
package pnoq_pkg;

  localparam int unsigned PITCH_W = 7;
  localparam int unsigned PITCHES = 1 << PITCH_W;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ORDER_W = 32;
  localparam int unsigned CNT_W   = 8;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_POP_DUE = 2'd2,
    OP_POP_ALL = 2'd3
  } op_e;

  typedef struct packed {
    logic               popped;
    logic [PITCH_W-1:0] out_pitch;
    logic [TIME_W-1:0]  out_time;
    logic [CNT_W-1:0]   pending_count;
  } pnoq_res_t;

endpackage

### hw/rtl/pnoq_if.sv
// request and result channel interfaces of the pending note-off queue
interface pnoq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] event_time;
  logic [6:0]  note_pitch;

  modport source (output valid, output operation, output event_time, output note_pitch,
                  input ready);
  modport sink (input valid, input operation, input event_time, input note_pitch,
                output ready);
endinterface

interface pnoq_out_if;
  logic        valid;
  logic        ready;
  logic        popped;
  logic [6:0]  out_pitch;
  logic [31:0] out_time;
  logic [7:0]  pending_count;

  modport source (output valid, output popped, output out_pitch, output out_time,
                  output pending_count, input ready);
  modport sink (input valid, input popped, input out_pitch, input out_time,
                input pending_count, output ready);
endinterface

### hw/rtl/pnoq_ram.sv
// simple dual-port synchronous ram with registered read data
module pnoq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pnoq_ctrl.sv
// sequencer: scans the per-pitch tables for the earliest entry, inserts and renumbers
module pnoq_ctrl #(
  parameter int unsigned SLOTS     = 128,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  pnoq_in_if.sink                 in_i,
  output pnoq_pkg::pnoq_res_t     res_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output logic [pnoq_pkg::PITCH_W-1:0] rd_addr_o,
  output logic [pnoq_pkg::PITCH_W-1:0] wr_addr_o,
  output logic                    time_we_o,
  output logic                    order_we_o,
  output logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] time_wdata_o,
  output logic [pnoq_pkg::ORDER_W-1:0] order_wdata_o,
  input  logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] time_rdata_i,
  input  logic [pnoq_pkg::ORDER_W-1:0] order_rdata_i
);
  import pnoq_pkg::*;

  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_ENQ, S_CHK, S_SCAN, S_FIN, S_POP, S_RWR, S_INS, S_RESP
  } state_e;

  state_e             state_q;
  op_e                op_q;
  logic [TW-1:0]      time_q;
  logic [PITCH_W-1:0] pitch_q;
  logic [PITCHES-1:0] valid_q;
  logic [PITCHES-1:0] done_q;
  logic [CNT_W-1:0]   count_q;
  logic [ORDER_W-1:0] ctr_q;
  logic [PITCH_W-1:0] idx_q;
  logic               pend_q;
  logic [PITCH_W-1:0] pend_idx_q;
  logic               renum_q;
  logic               best_found_q;
  logic [PITCH_W-1:0] best_idx_q;
  logic [TW-1:0]      best_time_q;
  logic [ORDER_W-1:0] best_ord_q;
  logic [CNT_W-1:0]   rank_q;
  logic               popped_q;
  logic [PITCH_W-1:0] out_pitch_q;
  logic [TW-1:0]      out_time_q;

  logic cand_ok;
  logic ord_lt;
  logic time_lt;
  logic time_eq;
  logic better;

  always_comb begin
    cand_ok = pend_q && valid_q[pend_idx_q] && !(renum_q && done_q[pend_idx_q]);
    ord_lt  = order_rdata_i < best_ord_q;
    time_lt = time_rdata_i < best_time_q;
    time_eq = time_rdata_i == best_time_q;
    better  = !best_found_q || (renum_q ? ord_lt : (time_lt || (time_eq && ord_lt)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_CLEAR;
      time_q       <= '0;
      pitch_q      <= '0;
      valid_q      <= '0;
      done_q       <= '0;
      count_q      <= '0;
      ctr_q        <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      renum_q      <= 1'b0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_time_q  <= '0;
      best_ord_q   <= '0;
      rank_q       <= '0;
      popped_q     <= 1'b0;
      out_pitch_q  <= '0;
      out_time_q   <= '0;
    end else begin
      // compare stage of the scan, one entry per cycle
      if (cand_ok && better) begin
        best_found_q <= 1'b1;
        best_idx_q   <= pend_idx_q;
        best_time_q  <= time_rdata_i;
        best_ord_q   <= order_rdata_i;
      end
      pend_q     <= (state_q == S_SCAN);
      pend_idx_q <= idx_q;

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q         <= op_e'(in_i.operation);
            time_q       <= in_i.event_time[TW-1:0];
            pitch_q      <= in_i.note_pitch;
            popped_q     <= 1'b0;
            out_pitch_q  <= '0;
            out_time_q   <= '0;
            best_found_q <= 1'b0;
            idx_q        <= '0;
            renum_q      <= 1'b0;
            unique case (op_e'(in_i.operation))
              OP_CLEAR:   state_q <= S_CLR;
              OP_ENQUEUE: state_q <= S_ENQ;
              default:    state_q <= (count_q == '0) ? S_POP : S_SCAN;
            endcase
          end
        end
        S_CLR: begin
          valid_q <= '0;
          count_q <= '0;
          ctr_q   <= '0;
          state_q <= S_RESP;
        end
        S_ENQ: begin
          if (valid_q[pitch_q]) begin
            valid_q[pitch_q] <= 1'b0;
            count_q          <= count_q - CNT_W'(1);
          end
          state_q <= S_CHK;
        end
        S_CHK: begin
          priority if (count_q >= CNT_W'(SLOTS)) begin
            state_q <= S_RESP;
          end else if (ctr_q == '1) begin
            if (count_q == '0) begin
              ctr_q   <= '0;
              state_q <= S_INS;
            end else begin
              done_q       <= '0;
              rank_q       <= '0;
              renum_q      <= 1'b1;
              idx_q        <= '0;
              best_found_q <= 1'b0;
              state_q      <= S_SCAN;
            end
          end else begin
            state_q <= S_INS;
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + PITCH_W'(1);
          if (idx_q == PITCH_W'(PITCHES - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          state_q <= renum_q ? S_RWR : S_POP;
        end
        S_POP: begin
          if (best_found_q && (op_q == OP_POP_ALL || best_time_q <= time_q)) begin
            valid_q[best_idx_q] <= 1'b0;
            count_q             <= count_q - CNT_W'(1);
            popped_q            <= 1'b1;
            out_pitch_q         <= best_idx_q;
            out_time_q          <= best_time_q;
          end
          state_q <= S_RESP;
        end
        S_RWR: begin
          done_q[best_idx_q] <= 1'b1;
          rank_q             <= rank_q + CNT_W'(1);
          best_found_q       <= 1'b0;
          idx_q              <= '0;
          if ((rank_q + CNT_W'(1)) == count_q) begin
            ctr_q   <= ORDER_W'(count_q);
            renum_q <= 1'b0;
            state_q <= S_INS;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_INS: begin
          valid_q[pitch_q] <= 1'b1;
          count_q          <= count_q + CNT_W'(1);
          ctr_q            <= ctr_q + ORDER_W'(1);
          state_q          <= S_RESP;
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

  always_comb begin
    res_o.popped        = popped_q;
    res_o.out_pitch     = out_pitch_q;
    res_o.out_time      = TIME_W'(out_time_q);
    res_o.pending_count = count_q;
  end

  // ram access
  assign rd_addr_o     = idx_q;
  assign wr_addr_o     = (state_q == S_RWR) ? best_idx_q : pitch_q;
  assign time_we_o     = (state_q == S_INS);
  assign order_we_o    = (state_q == S_INS) || (state_q == S_RWR);
  assign time_wdata_o  = time_q;
  assign order_wdata_o = (state_q == S_RWR) ? ORDER_W'(rank_q) : ctr_q;

endmodule

### hw/rtl/pending_note_off_queue.sv
// top level of the pending note-off queue: tables, sequencer and result register
//
// usage
//   in_i carries one request word: operation, event_time, note_pitch. a word is
//   taken when valid and ready are high at a clock edge; ready is high only while
//   the block is idle, so one request is in flight at a time.
//   out_o returns exactly one result word per request: popped, out_pitch,
//   out_time and pending_count. the result sits in an output register, so the
//   next request is taken while the previous result waits to be read.
// sequencing
//   clear: S_CLR, then the result. enqueue: S_ENQ and S_CHK, then S_INS unless
//   the table is full. pop on an empty table: S_POP without a scan.
//   pop otherwise: a scan over all PITCHES table entries, then S_FIN and S_POP;
//   the scan reads one table entry per cycle through the time and order rams.
//   an enqueue that finds the insertion counter exhausted first renumbers the
//   pending entries, one scan per pending entry.
// reset
//   all entries are invalid and the insertion counter is zero at once; no
//   clearing pass runs. a stalled receiver holds the result register and the
//   sequencer waits with its finished result until the register frees up.
module pending_note_off_queue #(
  parameter int unsigned SLOTS     = 128,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pnoq_in_if.sink    in_i,
  pnoq_out_if.source out_o
);
  import pnoq_pkg::*;

  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;

  pnoq_res_t          res;
  logic               res_valid;
  logic               res_ready;
  logic [PITCH_W-1:0] rd_addr;
  logic [PITCH_W-1:0] wr_addr;
  logic               time_we;
  logic               order_we;
  logic [TW-1:0]      time_wdata;
  logic [ORDER_W-1:0] order_wdata;
  logic [TW-1:0]      time_rdata;
  logic [ORDER_W-1:0] order_rdata;

  logic      out_valid_q;
  pnoq_res_t out_q;

  pnoq_ctrl #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .res_o         (res),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .time_we_o     (time_we),
    .order_we_o    (order_we),
    .time_wdata_o  (time_wdata),
    .order_wdata_o (order_wdata),
    .time_rdata_i  (time_rdata),
    .order_rdata_i (order_rdata)
  );

  pnoq_ram #(
    .WIDTH (TW),
    .DEPTH (PITCHES)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (wr_addr),
    .wdata_i (time_wdata),
    .raddr_i (rd_addr),
    .rdata_o (time_rdata)
  );

  pnoq_ram #(
    .WIDTH (ORDER_W),
    .DEPTH (PITCHES)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (order_we),
    .waddr_i (wr_addr),
    .wdata_i (order_wdata),
    .raddr_i (rd_addr),
    .rdata_o (order_rdata)
  );

  // result register
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.popped        = out_q.popped;
  assign out_o.out_pitch     = out_q.out_pitch;
  assign out_o.out_time      = out_q.out_time;
  assign out_o.pending_count = out_q.pending_count;

endmodule
